### rtl/core/sroe_pkg.sv
`default_nettype none
package sroe_pkg;

  // request codes as carried on req_type_i
  typedef enum logic [2:0] {
    REQ_INSERT  = 3'd0,
    REQ_ERASE   = 3'd1,
    REQ_ADD     = 3'd2,
    REQ_REVERSE = 3'd3,
    REQ_ROTATE  = 3'd4,
    REQ_MIN     = 3'd5
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  localparam int unsigned POS_W   = 13;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned CNT_W   = 31;
  localparam int unsigned LEN_OUT_W = 13;

endpackage
`default_nettype wire

### rtl/core/sequence_range_ops_engine_core.sv
`default_nettype none
// Ordered sequence of signed 64-bit values held in one synchronous RAM of
// DEPTH entries, addressed by 1-based position. One request is taken at a
// time; in_stall_o is high from the transfer until the request is finished.
// Insert and erase shift the tail one entry a cycle, range add and range
// minimum stream the range one entry a cycle, reverse swaps pairs through
// the single RAM port pair, reading both entries and then writing both, and
// rotate first runs a remainder unit, then three reversals. Rejected
// requests go from the transfer straight to S_FIN.
// The finished result sits in an output register, so the next request can
// transfer while the previous result is still stalled. Entries beyond the
// current length are never used; the RAM needs no clearing after reset.
module sequence_range_ops_engine_core #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [2:0]                           req_type_i,
  input  logic [sroe_pkg::POS_W-1:0]           first_pos_i,
  input  logic [sroe_pkg::POS_W-1:0]           last_pos_i,
  input  logic signed [sroe_pkg::VAL_W-1:0]    value_operand_i,
  input  logic [sroe_pkg::CNT_W-1:0]           rotate_count_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           status_o,
  output logic signed [sroe_pkg::VAL_W-1:0]    range_min_o,
  output logic [sroe_pkg::LEN_OUT_W-1:0]       seq_length_o
);
  import sroe_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);
  // position arithmetic width: holds both port positions and the length
  localparam int unsigned PW = (LW > POS_W) ? LW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STREAM,
    S_INS_PUT,
    S_ROT_DIV,
    S_FL_CHK,
    S_FL_RLO,
    S_FL_RHI,
    S_FL_WLO,
    S_FL_WHI,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  req_e   op_q, op_d;

  logic [LW-1:0]    len_q, len_d;
  logic [PW-1:0]    ptr_q, ptr_d, cnt_q, cnt_d, paddr_q, paddr_d;
  logic             pvld_q, pvld_d;
  logic [PW-1:0]    a0_q, a0_d, b0_q, b0_d, t_q, t_d;
  logic [PW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [1:0]       fidx_q, fidx_d, flast_q, flast_d;
  logic [VAL_W-1:0] val_q, val_d, tmp_q, tmp_d, min_q, min_d;
  logic             minv_q, minv_d;
  status_e          st_q, st_d;

  logic                 out_valid_q, out_valid_d;
  status_e              ost_q, ost_d;
  logic [VAL_W-1:0]     omin_q, omin_d;
  logic [LEN_OUT_W-1:0] olen_q, olen_d;

  // RAM port signals
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  // remainder unit for rotate
  logic          div_start, div_done;
  logic [PW-1:0] div_rem;

  // request decode, positions widened to PW
  logic [PW-1:0] pa, pb, plen;
  logic          rng_ok, in_xfer, out_xfer;

  assign pa       = PW'(first_pos_i);
  assign pb       = PW'(last_pos_i);
  assign plen     = PW'(len_q);
  assign rng_ok   = (pa != '0) && (pa <= pb) && (pb <= plen);
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_q && !out_stall_i;

  assign in_stall_o = (state_q != S_IDLE);
  assign div_start  = in_xfer && (req_e'(req_type_i) == REQ_ROTATE) && rng_ok;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    len_d     = len_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    paddr_d   = paddr_q;
    pvld_d    = pvld_q;
    a0_d      = a0_q;
    b0_d      = b0_q;
    t_d       = t_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    fidx_d    = fidx_q;
    flast_d   = flast_q;
    val_d     = val_q;
    tmp_d     = tmp_q;
    min_d     = min_q;
    minv_d    = minv_q;
    st_d      = st_q;
    ram_we    = 1'b0;
    ram_waddr = paddr_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = ptr_q[AW-1:0];

    out_valid_d = out_xfer ? 1'b0 : out_valid_q;
    ost_d       = ost_q;
    omin_d      = omin_q;
    olen_d      = olen_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d   = req_e'(req_type_i);
          val_d  = value_operand_i;
          min_d  = '0;
          minv_d = 1'b0;
          pvld_d = 1'b0;
          st_d   = ST_DONE;
          state_d = S_FIN;
          unique case (req_e'(req_type_i))
            REQ_INSERT: begin
              if (pa > plen) begin
                st_d = ST_INVALID;
              end else if (len_q >= LW'(DEPTH)) begin
                st_d = ST_FULL;
              end else begin
                a0_d    = pa;
                ptr_d   = plen - PW'(1);
                cnt_d   = plen - pa;
                state_d = S_STREAM;
              end
            end
            REQ_ERASE: begin
              if ((pa == '0) || (pa > plen)) begin
                st_d = ST_INVALID;
              end else begin
                ptr_d   = pa;
                cnt_d   = plen - pa;
                state_d = S_STREAM;
              end
            end
            REQ_ADD, REQ_MIN: begin
              if (!rng_ok) begin
                st_d = ST_INVALID;
              end else begin
                ptr_d   = pa - PW'(1);
                cnt_d   = pb - pa + PW'(1);
                state_d = S_STREAM;
              end
            end
            REQ_REVERSE: begin
              if (!rng_ok) begin
                st_d = ST_INVALID;
              end else begin
                lo_d    = pa - PW'(1);
                hi_d    = pb - PW'(1);
                fidx_d  = 2'd0;
                flast_d = 2'd0;
                state_d = S_FL_CHK;
              end
            end
            REQ_ROTATE: begin
              if (!rng_ok) begin
                st_d = ST_INVALID;
              end else begin
                a0_d    = pa - PW'(1);
                b0_d    = pb - PW'(1);
                state_d = S_ROT_DIV;
              end
            end
            default: begin
              st_d = ST_INVALID;
            end
          endcase
        end
      end

      // read one entry a cycle, handle the data in the next cycle
      S_STREAM: begin
        if (pvld_q) begin
          unique case (op_q)
            REQ_INSERT, REQ_ERASE: begin
              ram_we = 1'b1;
            end
            REQ_ADD: begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata + val_q;
            end
            REQ_MIN: begin
              if (!minv_q || ($signed(ram_rdata) < $signed(min_q))) begin
                min_d = ram_rdata;
              end
              minv_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
        if (cnt_q != '0) begin
          cnt_d  = cnt_q - PW'(1);
          pvld_d = 1'b1;
          unique case (op_q)
            REQ_INSERT: begin
              ptr_d   = ptr_q - PW'(1);
              paddr_d = ptr_q + PW'(1);
            end
            REQ_ERASE: begin
              ptr_d   = ptr_q + PW'(1);
              paddr_d = ptr_q - PW'(1);
            end
            default: begin
              ptr_d   = ptr_q + PW'(1);
              paddr_d = ptr_q;
            end
          endcase
        end else begin
          pvld_d = 1'b0;
          if (!pvld_q) begin
            unique case (op_q)
              REQ_INSERT: state_d = S_INS_PUT;
              REQ_ERASE: begin
                len_d   = len_q - LW'(1);
                state_d = S_FIN;
              end
              default: state_d = S_FIN;
            endcase
          end
        end
      end

      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = a0_q[AW-1:0];
        ram_wdata = val_q;
        len_d     = len_q + LW'(1);
        state_d   = S_FIN;
      end

      // right rotation by t as three reversals; nothing to do when t is zero
      S_ROT_DIV: begin
        if (div_done) begin
          t_d = div_rem;
          if (div_rem == '0) begin
            state_d = S_FIN;
          end else begin
            lo_d    = a0_q;
            hi_d    = b0_q;
            fidx_d  = 2'd0;
            flast_d = 2'd2;
            state_d = S_FL_CHK;
          end
        end
      end

      S_FL_CHK: begin
        if (lo_q < hi_q) begin
          state_d = S_FL_RLO;
        end else if (fidx_q == flast_q) begin
          state_d = S_FIN;
        end else begin
          fidx_d = fidx_q + 2'd1;
          if (fidx_q == 2'd0) begin
            lo_d = a0_q;
            hi_d = a0_q + t_q - PW'(1);
          end else begin
            lo_d = a0_q + t_q;
            hi_d = b0_q;
          end
        end
      end

      S_FL_RLO: begin
        ram_raddr = lo_q[AW-1:0];
        state_d   = S_FL_RHI;
      end

      S_FL_RHI: begin
        ram_raddr = hi_q[AW-1:0];
        tmp_d     = ram_rdata;
        state_d   = S_FL_WLO;
      end

      S_FL_WLO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[AW-1:0];
        ram_wdata = ram_rdata;
        state_d   = S_FL_WHI;
      end

      S_FL_WHI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q[AW-1:0];
        ram_wdata = tmp_q;
        lo_d      = lo_q + PW'(1);
        hi_d      = hi_q - PW'(1);
        state_d   = S_FL_CHK;
      end

      // hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          ost_d       = st_q;
          omin_d      = min_q;
          olen_d      = LEN_OUT_W'(len_q);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= REQ_INSERT;
      len_q       <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      paddr_q     <= '0;
      pvld_q      <= 1'b0;
      a0_q        <= '0;
      b0_q        <= '0;
      t_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      fidx_q      <= '0;
      flast_q     <= '0;
      val_q       <= '0;
      tmp_q       <= '0;
      min_q       <= '0;
      minv_q      <= 1'b0;
      st_q        <= ST_DONE;
      out_valid_q <= 1'b0;
      ost_q       <= ST_DONE;
      omin_q      <= '0;
      olen_q      <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      len_q       <= len_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      paddr_q     <= paddr_d;
      pvld_q      <= pvld_d;
      a0_q        <= a0_d;
      b0_q        <= b0_d;
      t_q         <= t_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      fidx_q      <= fidx_d;
      flast_q     <= flast_d;
      val_q       <= val_d;
      tmp_q       <= tmp_d;
      min_q       <= min_d;
      minv_q      <= minv_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      ost_q       <= ost_d;
      omin_q      <= omin_d;
      olen_q      <= olen_d;
    end
  end

  sroe_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sroe_divmod #(
    .PW (PW)
  ) u_divmod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rotate_count_i),
    .divisor_i  (pb - pa + PW'(1)),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = ost_q;
  assign range_min_o  = omin_q;
  assign seq_length_o = olen_q;

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(DEPTH))
    else $error("length beyond depth");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("request taken while busy");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != S_IDLE))
    else $error("store written while idle");

endmodule
`default_nettype wire

### rtl/core/sroe_ram.sv
`default_nettype none
module sroe_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/core/sroe_divmod.sv
`default_nettype none
module sroe_divmod #(
  parameter int unsigned PW = 13
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sroe_pkg::CNT_W-1:0]   dividend_i,
  input  logic [PW-1:0]                divisor_i,
  output logic                         done_o,
  output logic [PW-1:0]                rem_o
);
  import sroe_pkg::*;

  localparam int unsigned SW = $clog2(CNT_W + 1);

  logic [CNT_W-1:0] dvd_q;
  logic [PW-1:0]    dvs_q;
  logic [PW:0]      rem_q, rem_d, shifted;
  logic [SW-1:0]    step_q;
  logic             busy_q, done_q;

  // one restoring step per cycle, dividend bits msb first
  always_comb begin
    shifted = {rem_q[PW-1:0], dvd_q[CNT_W-1]};
    if (shifted >= {1'b0, dvs_q}) begin
      rem_d = shifted - {1'b0, dvs_q};
    end else begin
      rem_d = shifted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= SW'(CNT_W);
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q  <= rem_d;
        dvd_q  <= {dvd_q[CNT_W-2:0], 1'b0};
        step_q <= step_q - SW'(1);
        if (step_q == SW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[PW-1:0];

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rem_q < {1'b0, dvs_q}))
    else $error("remainder not below divisor");

endmodule
`default_nettype wire
